### hw/rtl/pust_pkg.sv
// Package for the per-user anomaly score table: payload structs, codes,
// decay thresholds and controller/datapath command and status structs.
`default_nettype none
package pust_pkg;
   typedef struct packed {
      logic [31:0] user_id;
      logic [31:0] prog_id;
      logic        on_local_fs;
      logic [9:0]  event_weight;
   } req_type;

   typedef struct packed {
      logic [2:0]  alert_class;
      logic [15:0] level_after;
      logic        new_user;
      logic        new_program;
      logic        table_full;
      logic        scored;
   } rsp_type;

   localparam logic CSR_NEW_PROG   = 1'b0;
   localparam logic CSR_KNOWN_PROG = 1'b1;
   localparam logic [9:0] NEW_PROG_RESET   = 10'd10;
   localparam logic [9:0] KNOWN_PROG_RESET = 10'd1;
   localparam logic [16:0] LEVEL_MAX = 17'd65535;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request
      logic user_scan;   // compare user RAM word of previous address
      logic prog_scan;   // compare prog RAM word of previous address
      logic user_write;  // allocate user
      logic prog_write;  // allocate pair
      logic level_read;  // read level RAM
      logic score;       // saturate and decay
      logic level_write; // write level
      logic finish;      // build response
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic user_hit;
      logic user_free;
      logic prog_hit;
      logic prog_free;
      logic on_local_fs;
   } sts_type;

   function automatic logic [18:0] decay(input logic [15:0] lvl_i);
      // returns {class, level}
      case (1'b1)
         (lvl_i >= 16'd999): decay = {3'd4, lvl_i - 16'd99};
         (lvl_i >= 16'd900): decay = {3'd3, lvl_i - 16'd80};
         (lvl_i >= 16'd800): decay = {3'd2, lvl_i - 16'd50};
         (lvl_i >= 16'd700): decay = {3'd1, lvl_i - 16'd30};
         (lvl_i >= 16'd400): decay = {3'd0, lvl_i - 16'd7};
         (lvl_i >= 16'd300): decay = {3'd0, lvl_i - 16'd5};
         default:            decay = {3'd0, lvl_i};
      endcase
   endfunction
endpackage
`default_nettype wire

### hw/rtl/pust_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module pust_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

### hw/rtl/pust_datapath.sv
// Datapath: user and program tables, scan compare, scoring arithmetic.
// Depends on pust_pkg and pust_ram.
`default_nettype none
module pust_datapath import pust_pkg::*; #(
   parameter int USER_SLOTS = 64,
   parameter int PROG_SLOTS = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmd_type                       cmd,
   input  wire req_type                       req,
   input  wire logic [$clog2(USER_SLOTS)-1:0] uaddr,
   input  wire logic [$clog2(PROG_SLOTS)-1:0] paddr,
   input  wire logic [9:0]                    new_pen,
   input  wire logic [9:0]                    known_pen,
   output sts_type                            sts,
   output rsp_type                            rsp
);
   localparam int UW = $clog2(USER_SLOTS);
   localparam int PW = $clog2(PROG_SLOTS);

   req_type          req_ff;
   logic [UW-1:0]    uslot_ff, uslot_in;
   logic             uhit_ff, uhit_in, ufree_ff, ufree_in;
   logic [UW-1:0]    ufree_slot_ff, ufree_slot_in;
   logic             phit_ff, phit_in, pfree_ff, pfree_in;
   logic [PW-1:0]    pfree_slot_ff, pfree_slot_in;
   logic [UW-1:0]    uaddr_ff;
   logic [PW-1:0]    paddr_ff;
   // slots fill lowest first and are never freed: slot i is valid when i < count
   logic [UW:0]      ucount_ff;
   logic [PW:0]      pcount_ff;
   logic [31:0]      ukey_rd, pino_rd;
   logic [UW-1:0]    pown_rd;
   logic [15:0]      lvl_rd;
   logic [15:0]      lvl_ff, lvl_in;
   logic [2:0]       cls_ff, cls_in;
   logic             nu_ff, np_ff;
   rsp_type          rsp_ff;
   logic [UW-1:0]    tgt_slot;
   logic [UW-1:0]    ram_uaddr;
   logic             lvl_we;
   logic [15:0]      lvl_wd;
   logic [16:0]      sum;
   logic [15:0]      sat;
   logic [18:0]      dec;

   assign tgt_slot  = uhit_ff ? uslot_ff : ufree_slot_ff;
   assign ram_uaddr = (cmd.user_write | cmd.level_read | cmd.level_write) ? tgt_slot : uaddr;
   assign lvl_we    = cmd.user_write | cmd.level_write;
   assign lvl_wd    = cmd.level_write ? lvl_ff : 16'd1;

   pust_ram #(.WIDTH(32), .DEPTH(USER_SLOTS)) u_key (
      .clock, .we(cmd.user_write), .addr(ram_uaddr), .wdata(req_ff.user_id), .rdata(ukey_rd));
   pust_ram #(.WIDTH(16), .DEPTH(USER_SLOTS)) u_lvl (
      .clock, .we(lvl_we), .addr(ram_uaddr), .wdata(lvl_wd), .rdata(lvl_rd));
   pust_ram #(.WIDTH(UW), .DEPTH(PROG_SLOTS)) u_own (
      .clock, .we(cmd.prog_write), .addr(cmd.prog_write ? pfree_slot_ff : paddr),
      .wdata(tgt_slot), .rdata(pown_rd));
   pust_ram #(.WIDTH(32), .DEPTH(PROG_SLOTS)) u_ino (
      .clock, .we(cmd.prog_write), .addr(cmd.prog_write ? pfree_slot_ff : paddr),
      .wdata(req_ff.prog_id), .rdata(pino_rd));

   always_comb begin
      uhit_in = uhit_ff; ufree_in = ufree_ff; uslot_in = uslot_ff;
      ufree_slot_in = ufree_slot_ff;
      phit_in = phit_ff; pfree_in = pfree_ff; pfree_slot_in = pfree_slot_ff;
      if (cmd.load) begin
         uhit_in = 1'b0; ufree_in = 1'b0; phit_in = 1'b0; pfree_in = 1'b0;
      end
      if (cmd.user_scan) begin
         if ({1'b0, uaddr_ff} < ucount_ff) begin
            if (!uhit_ff && ukey_rd == req_ff.user_id) begin
               uhit_in = 1'b1; uslot_in = uaddr_ff;
            end
         end else if (!ufree_ff) begin
            ufree_in = 1'b1; ufree_slot_in = uaddr_ff;
         end
      end
      if (cmd.prog_scan) begin
         if ({1'b0, paddr_ff} < pcount_ff) begin
            if (uhit_ff && !phit_ff && pown_rd == uslot_ff && pino_rd == req_ff.prog_id)
               phit_in = 1'b1;
         end else if (!pfree_ff) begin
            pfree_in = 1'b1; pfree_slot_in = paddr_ff;
         end
      end
   end

   assign sum = {1'b0, lvl_rd} + {7'd0, phit_ff ? known_pen : new_pen}
              + {7'd0, req_ff.event_weight};
   assign sat = (sum > LEVEL_MAX) ? 16'hFFFF : sum[15:0];
   assign dec = decay(sat);

   always_comb begin
      lvl_in = lvl_ff; cls_in = cls_ff;
      if (cmd.load) begin
         cls_in = 3'd0;
      end else if (cmd.score) begin
         lvl_in = dec[15:0]; cls_in = dec[18:16];
      end else if (cmd.level_read) begin
         lvl_in = lvl_rd;
      end
   end

   always_ff @(posedge clock) begin
      uaddr_ff <= uaddr; paddr_ff <= paddr;
      uslot_ff <= uslot_in; ufree_slot_ff <= ufree_slot_in; pfree_slot_ff <= pfree_slot_in;
      lvl_ff <= lvl_in; cls_ff <= cls_in;
      if (cmd.load) begin
         req_ff <= req; nu_ff <= 1'b0; np_ff <= 1'b0;
      end
      if (cmd.user_write) nu_ff <= 1'b1;
      if (cmd.prog_write) np_ff <= 1'b1;
      if (cmd.finish) begin
         // no slot anywhere: full, report known user's level or zero
         if (!uhit_ff && !ufree_ff) begin
            rsp_ff <= '{3'd0, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0};
         end else if (req_ff.on_local_fs && !phit_ff && !pfree_ff) begin
            rsp_ff <= '{3'd0, uhit_ff ? lvl_in : 16'd0, 1'b0, 1'b0, 1'b1, 1'b0};
         end else begin
            rsp_ff <= '{req_ff.on_local_fs ? cls_in : 3'd0, lvl_in, nu_ff, np_ff, 1'b0,
                        cmd.score};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uhit_ff <= 1'b0; ufree_ff <= 1'b0; phit_ff <= 1'b0; pfree_ff <= 1'b0;
         ucount_ff <= '0; pcount_ff <= '0;
      end else begin
         uhit_ff <= uhit_in; ufree_ff <= ufree_in; phit_ff <= phit_in; pfree_ff <= pfree_in;
         if (cmd.user_write) ucount_ff <= ucount_ff + 1'b1;
         if (cmd.prog_write) pcount_ff <= pcount_ff + 1'b1;
      end
   end

   assign sts = '{uhit_ff, ufree_ff, phit_ff, pfree_ff, req_ff.on_local_fs};
   assign rsp = rsp_ff;
endmodule
`default_nettype wire

### hw/rtl/pust_ctrl.sv
// Controller: sequences the user scan, program scan, allocation and scoring.
// Depends on pust_pkg.
`default_nettype none
module pust_ctrl import pust_pkg::*; #(
   parameter int USER_SLOTS = 64,
   parameter int PROG_SLOTS = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire sts_type                       sts,
   output cmd_type                            cmd,
   output logic [$clog2(USER_SLOTS)-1:0]      uaddr,
   output logic [$clog2(PROG_SLOTS)-1:0]      paddr
);
   localparam int UW = $clog2(USER_SLOTS);
   localparam int PW = $clog2(PROG_SLOTS);
   localparam logic [3:0] S_IDLE = 4'd0, S_USCAN = 4'd1, S_UTAIL = 4'd2,
                          S_PSCAN = 4'd3, S_PTAIL = 4'd4, S_DECIDE = 4'd5,
                          S_LREAD = 4'd6, S_LWAIT = 4'd7, S_SCORE = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [UW:0] ucnt_ff, ucnt_in;
   logic [PW:0] pcnt_ff, pcnt_in;
   logic        rv_ff, rv_in;
   logic        ok;

   assign uaddr = ucnt_ff[UW-1:0];
   assign paddr = pcnt_ff[PW-1:0];
   assign req_ready = (state_ff == S_IDLE) && (!rv_ff || rsp_ready);
   assign rsp_valid = rv_ff;
   assign ok = (sts.user_hit || sts.user_free) &&
               (!sts.on_local_fs || sts.prog_hit || sts.prog_free);

   always_comb begin
      state_in = state_ff; ucnt_in = ucnt_ff; pcnt_in = pcnt_ff;
      rv_in = rv_ff && !rsp_ready;
      cmd = '0;
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            cmd.load = 1'b1; ucnt_in = '0; state_in = S_USCAN;
         end
         S_USCAN: begin
            if (ucnt_ff != '0) cmd.user_scan = 1'b1;
            ucnt_in = ucnt_ff + 1'b1;
            if (ucnt_ff == (UW+1)'(USER_SLOTS - 1)) state_in = S_UTAIL;
         end
         S_UTAIL: begin
            cmd.user_scan = 1'b1; pcnt_in = '0;
            state_in = S_PSCAN;
         end
         S_PSCAN: begin
            // skip the scan when not tracked; pair lookup gated by user hit
            if (!sts.on_local_fs) state_in = S_DECIDE;
            else begin
               if (pcnt_ff != '0) cmd.prog_scan = 1'b1;
               pcnt_in = pcnt_ff + 1'b1;
               if (pcnt_ff == (PW+1)'(PROG_SLOTS - 1)) state_in = S_PTAIL;
            end
         end
         S_PTAIL: begin
            cmd.prog_scan = 1'b1; state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (ok) begin
               if (!sts.user_hit) cmd.user_write = 1'b1;
               if (sts.on_local_fs && !sts.prog_hit) cmd.prog_write = 1'b1;
            end
            state_in = S_LREAD;
         end
         S_LREAD: state_in = S_LWAIT;
         S_LWAIT: begin
            // level RAM data valid this cycle
            if (ok && sts.on_local_fs) state_in = S_SCORE;
            else begin
               cmd.level_read = 1'b1; cmd.finish = 1'b1;
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_SCORE: begin
            cmd.score = 1'b1; cmd.finish = 1'b1;
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // level RAM addressed by the target slot from level read through score
      if (state_ff == S_LREAD || state_ff == S_LWAIT) cmd.level_read = 1'b1;
      if (state_ff == S_SCORE) begin
         cmd.level_read = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ucnt_ff <= '0; pcnt_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ucnt_ff <= ucnt_in; pcnt_ff <= pcnt_in; rv_ff <= rv_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/pust_score_wb.sv
// Level write-back stage: writes the scored level in the cycle after scoring.
// Depends on pust_pkg.
`default_nettype none
module pust_score_wb import pust_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd_i,
   output cmd_type      cmd_o
);
   logic wb_ff;
   always_ff @(posedge clock) begin
      if (reset) wb_ff <= 1'b0;
      else       wb_ff <= cmd_i.score;
   end
   always_comb begin
      cmd_o = cmd_i;
      cmd_o.level_write = wb_ff;
   end
endmodule
`default_nettype wire

### hw/rtl/per_user_anomaly_score_table.sv
// Top level of the per-user anomaly score table.
// Depends on pust_pkg, pust_ctrl, pust_score_wb, pust_datapath.
//
//   channel | ports                 | handshake
//   request | req_valid/ready/data  | transfer when valid and ready
//   result  | rsp_valid/ready/data  | transfer when valid and ready
//   config  | csr_we/index/wdata    | write when csr_we
//
// Requests are handled one at a time, by sequential scans over the user and
// program memories, one read port each. The program scan and the scoring
// state are skipped when not on the local filesystem; scoring is also
// skipped when a table is full. Reset is synchronous and clears the table
// fill counts. A waiting result holds; the next request is taken in the
// cycle the result transfers, at the earliest the cycle rsp_valid rises.
`default_nettype none
module per_user_anomaly_score_table import pust_pkg::*; #(
   parameter int USER_SLOTS = 64,
   parameter int PROG_SLOTS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [9:0]  csr_wdata
);
   cmd_type cmd_c, cmd;
   sts_type sts;
   logic [$clog2(USER_SLOTS)-1:0] uaddr;
   logic [$clog2(PROG_SLOTS)-1:0] paddr;
   logic [9:0] new_pen_ff, known_pen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         new_pen_ff <= NEW_PROG_RESET; known_pen_ff <= KNOWN_PROG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NEW_PROG:   new_pen_ff   <= csr_wdata;
            CSR_KNOWN_PROG: known_pen_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   pust_ctrl #(.USER_SLOTS(USER_SLOTS), .PROG_SLOTS(PROG_SLOTS)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd(cmd_c), .uaddr, .paddr);

   pust_score_wb u_wb (.clock, .reset, .cmd_i(cmd_c), .cmd_o(cmd));

   pust_datapath #(.USER_SLOTS(USER_SLOTS), .PROG_SLOTS(PROG_SLOTS)) u_dp (
      .clock, .reset, .cmd, .req(req_data), .uaddr, .paddr,
      .new_pen(new_pen_ff), .known_pen(known_pen_ff), .sts, .rsp(rsp_data));
endmodule
`default_nettype wire
